// ===== src/fct_pkg.sv =====
// Shared constants, types and request codes of the chain table engine.
package fct_pkg;

  localparam int GROUP_COUNT       = 32;
  localparam int ENTRIES_PER_GROUP = 128;

  localparam int DEPTH     = 4096;
  localparam int IDX_W     = 12;
  localparam int ROW_W     = 32;
  localparam int ROW_SEL_W = $clog2(ROW_W);
  localparam int ROWS      = DEPTH / ROW_W;
  localparam int ROW_AW    = $clog2(ROWS);

  localparam int TBL_SIZE = (GROUP_COUNT * ENTRIES_PER_GROUP > DEPTH) ? DEPTH :
                            GROUP_COUNT * ENTRIES_PER_GROUP;
  localparam int LAST_ROW = (TBL_SIZE - 1) / ROW_W;
  localparam int HINT_W   = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  // group = (index * DIV_MULT) >> DIV_SHIFT, exact for every 12-bit index
  localparam int DIV_SHIFT = IDX_W + $clog2(ENTRIES_PER_GROUP);
  localparam int DIV_MULT  = ((1 << DIV_SHIFT) + ENTRIES_PER_GROUP - 1) / ENTRIES_PER_GROUP;
  localparam int MULT_W    = $clog2(DIV_MULT + 1);
  localparam int PROD_W    = IDX_W + MULT_W;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FOLLOW = 2'd1,
    REQ_FORMAT = 2'd2
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] next;
    logic             is_end;
  } link_t;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [ROW_W-1:0]  wdata;
    logic [ROW_AW-1:0] raddr;
  } used_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    link_t            wdata;
  } link_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             is_end;
    logic             full;
  } res_t;

endpackage

// ===== src/fct_used_ram.sv =====
// Allocated-mark memory: one row holds the marks of ROW_W neighbouring entries.
module fct_used_ram (
  input  logic                        clk,
  input  fct_pkg::used_req_t          req,
  output logic [fct_pkg::ROW_W-1:0]   rdata
);

  logic [fct_pkg::ROW_W-1:0] mem [fct_pkg::ROWS];
  logic [fct_pkg::ROW_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fct_link_ram.sv =====
// Next-link memory: link and end flag of every entry, single port.
module fct_link_ram (
  input  logic               clk,
  input  fct_pkg::link_req_t req,
  output fct_pkg::link_t     rdata
);

  fct_pkg::link_t mem [fct_pkg::DEPTH];
  fct_pkg::link_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata_r <= mem[req.addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/fct_ctrl.sv =====
// Request sequencer: clearing pass, row-wise free scan, follow lookup, hint upkeep.
module fct_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [fct_pkg::IDX_W-1:0]   in_link_index,
  input  logic                        in_link_is_end,
  input  logic [fct_pkg::IDX_W-1:0]   in_entry_index,
  output fct_pkg::used_req_t          used_req,
  input  logic [fct_pkg::ROW_W-1:0]   used_rdata,
  output fct_pkg::link_req_t          link_req,
  input  fct_pkg::link_t              link_rdata,
  output logic                        res_valid,
  output fct_pkg::res_t               res,
  input  logic                        res_take
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ACHK  = 7'b0000100,
    S_ADIV  = 7'b0001000,
    S_AGRP  = 7'b0010000,
    S_FCHK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [fct_pkg::IDX_W-1:0]  EPG_C   = fct_pkg::IDX_W'(fct_pkg::ENTRIES_PER_GROUP);
  localparam logic [fct_pkg::IDX_W:0]    TBL_C   = (fct_pkg::IDX_W+1)'(fct_pkg::TBL_SIZE);
  localparam logic [fct_pkg::ROW_AW-1:0] LAST_C  = fct_pkg::ROW_AW'(fct_pkg::LAST_ROW);
  localparam logic [fct_pkg::ROW_AW-1:0] ROWEND  = fct_pkg::ROW_AW'(fct_pkg::ROWS - 1);
  localparam logic [fct_pkg::PROD_W-1:0] MULT_C  = fct_pkg::PROD_W'(fct_pkg::DIV_MULT);
  localparam logic [fct_pkg::PROD_W-1:0] GC_C    = fct_pkg::PROD_W'(fct_pkg::GROUP_COUNT);

  state_t                        state_r, state_nxt;
  logic [fct_pkg::ROW_AW-1:0]    clr_row_r, clr_row_nxt;
  logic                          fmt_r, fmt_nxt;
  logic [fct_pkg::HINT_W-1:0]    hint_r, hint_nxt;
  logic [fct_pkg::IDX_W-1:0]     start_r, start_nxt;
  logic [fct_pkg::ROW_AW-1:0]    scan_row_r, scan_row_nxt;
  logic [fct_pkg::IDX_W-1:0]     link_idx_r, link_idx_nxt;
  logic                          link_end_r, link_end_nxt;
  logic [fct_pkg::IDX_W-1:0]     entry_r, entry_nxt;
  logic [fct_pkg::IDX_W-1:0]     found_r, found_nxt;
  logic [fct_pkg::PROD_W-1:0]    prod_r, prod_nxt;
  fct_pkg::res_t                 res_r, res_nxt;

  logic [fct_pkg::IDX_W-1:0]     hint_start;
  logic [fct_pkg::ROW_W-1:0]     free_mask;
  logic [fct_pkg::ROW_W-1:0]     first_free;
  logic [fct_pkg::ROW_SEL_W-1:0] first_pos;
  logic [fct_pkg::IDX_W-1:0]     found_idx;
  logic                          hit;
  logic                          accept;
  logic                          entry_used;

  assign accept     = in_valid && (state_r == S_IDLE);
  assign in_stall   = (state_r != S_IDLE);
  assign hint_start = fct_pkg::IDX_W'(hint_r) * EPG_C;

  // free entries of the current row inside [start, table size)
  always_comb begin
    for (int b = 0; b < fct_pkg::ROW_W; b++) begin
      free_mask[b] = !used_rdata[b] &&
                     ({1'b0, scan_row_r, fct_pkg::ROW_SEL_W'(b)} >= {1'b0, start_r}) &&
                     ({1'b0, scan_row_r, fct_pkg::ROW_SEL_W'(b)} <  TBL_C);
    end
    first_free = free_mask & (~free_mask + fct_pkg::ROW_W'(1));
    first_pos  = '0;
    for (int b = 0; b < fct_pkg::ROW_W; b++) begin
      if (first_free[b]) begin
        first_pos = first_pos | fct_pkg::ROW_SEL_W'(b);
      end
    end
  end

  assign hit        = |free_mask;
  assign found_idx  = {scan_row_r, first_pos};
  // entry 0 is never written in the link store: it reads as the root end link
  assign entry_used = used_rdata[entry_r[fct_pkg::ROW_SEL_W-1:0]] && (entry_r != '0);

  always_comb begin
    state_nxt    = state_r;
    clr_row_nxt  = clr_row_r;
    fmt_nxt      = fmt_r;
    hint_nxt     = hint_r;
    start_nxt    = start_r;
    scan_row_nxt = scan_row_r;
    link_idx_nxt = link_idx_r;
    link_end_nxt = link_end_r;
    entry_nxt    = entry_r;
    found_nxt    = found_r;
    prod_nxt     = prod_r;
    res_nxt      = res_r;

    used_req.we    = 1'b0;
    used_req.waddr = clr_row_r;
    used_req.wdata = '0;
    used_req.raddr = scan_row_r;

    link_req.we           = 1'b0;
    link_req.addr         = in_entry_index;
    link_req.wdata.next   = link_end_r ? '0 : link_idx_r;
    link_req.wdata.is_end = link_end_r;

    case (state_r)
      S_CLEAR: begin
        used_req.we    = 1'b1;
        used_req.wdata = (clr_row_r == '0) ? fct_pkg::ROW_W'(1) : '0;
        clr_row_nxt    = clr_row_r + 1'b1;
        if (clr_row_r == ROWEND) begin
          clr_row_nxt = '0;
          fmt_nxt     = 1'b0;
          res_nxt     = '0;
          state_nxt   = fmt_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        used_req.raddr = (in_req_type == fct_pkg::REQ_FOLLOW) ?
                         in_entry_index[fct_pkg::IDX_W-1:fct_pkg::ROW_SEL_W] :
                         hint_start[fct_pkg::IDX_W-1:fct_pkg::ROW_SEL_W];
        if (accept) begin
          link_idx_nxt = in_link_index;
          link_end_nxt = in_link_is_end;
          entry_nxt    = in_entry_index;
          start_nxt    = hint_start;
          scan_row_nxt = hint_start[fct_pkg::IDX_W-1:fct_pkg::ROW_SEL_W];
          res_nxt      = '0;
          case (in_req_type)
            fct_pkg::REQ_ALLOC:  state_nxt = S_ACHK;
            fct_pkg::REQ_FOLLOW: state_nxt = S_FCHK;
            fct_pkg::REQ_FORMAT: begin
              hint_nxt    = '0;
              fmt_nxt     = 1'b1;
              clr_row_nxt = '0;
              state_nxt   = S_CLEAR;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ACHK: begin
        // fetch the following row while this one is examined
        scan_row_nxt   = scan_row_r + 1'b1;
        used_req.raddr = scan_row_nxt;
        if (hit) begin
          used_req.we    = 1'b1;
          used_req.waddr = scan_row_r;
          used_req.wdata = used_rdata | first_free;
          link_req.we    = 1'b1;
          link_req.addr  = found_idx;
          found_nxt      = found_idx;
          scan_row_nxt   = scan_row_r;
          state_nxt      = S_ADIV;
        end else if (scan_row_r == LAST_C) begin
          res_nxt.full = 1'b1;
          scan_row_nxt = scan_row_r;
          state_nxt    = S_DONE;
        end
      end
      S_ADIV: begin
        prod_nxt  = fct_pkg::PROD_W'(found_r) * MULT_C;
        state_nxt = S_AGRP;
      end
      S_AGRP: begin
        hint_nxt      = fct_pkg::HINT_W'(prod_r >> fct_pkg::DIV_SHIFT);
        res_nxt.index = found_r;
        state_nxt     = S_DONE;
      end
      S_FCHK: begin
        if (entry_used && !link_rdata.is_end) begin
          res_nxt.index = link_rdata.next;
        end else begin
          res_nxt.is_end = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_row_r <= '0;
      fmt_r     <= 1'b0;
      hint_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      fmt_r     <= fmt_nxt;
      hint_r    <= hint_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r    <= start_nxt;
    scan_row_r <= scan_row_nxt;
    link_idx_r <= link_idx_nxt;
    link_end_r <= link_end_nxt;
    entry_r    <= entry_nxt;
    found_r    <= found_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  a_hint_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fct_pkg::PROD_W'(hint_r) < GC_C)
    else $error("free hint group out of range");

  a_group_not_behind_hint: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AGRP) |->
      ((prod_r >> fct_pkg::DIV_SHIFT) >= fct_pkg::PROD_W'(hint_r)) &&
      ((prod_r >> fct_pkg::DIV_SHIFT) < GC_C))
    else $error("allocated entry maps to a group outside the scanned range");

  a_alloc_not_below_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AGRP) |=> (res_r.index >= $past(start_r)) && !res_r.full)
    else $error("allocated entry lies before the hint group");

  a_no_write_outside_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !used_req.we && !link_req.we)
    else $error("table written while no request is in progress");

endmodule

// ===== src/fat_chain_table_engine.sv =====
// Top level of the chain table engine: sequencer, both table memories, result register.
//
//  channel | direction | ports                                        | handshake
//  --------+-----------+----------------------------------------------+-----------------
//  in      | input     | req_type, link_index, link_is_end, entry_index | in_valid/in_stall
//  out     | output    | result_index, result_is_end, table_full      | out_valid/out_stall
//
// Follow reads the entry's allocated mark and link, then loads the result register; allocate
// scans one 32-entry row of allocated marks a cycle from the hint group (at most 128 rows),
// then derives the new hint group; format runs the clearing pass over the allocated-mark memory,
// one row a cycle. After reset the same clearing pass runs with in_stall high before the first word.
// One request is in progress at a time; a finished result waits in the output register,
// so a new word is taken while out_stall holds the previous one.
module fat_chain_table_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [fct_pkg::IDX_W-1:0] in_link_index,
  input  logic                      in_link_is_end,
  input  logic [fct_pkg::IDX_W-1:0] in_entry_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fct_pkg::IDX_W-1:0] out_result_index,
  output logic                      out_result_is_end,
  output logic                      out_table_full
);

  fct_pkg::used_req_t        used_req;
  logic [fct_pkg::ROW_W-1:0] used_rdata;
  fct_pkg::link_req_t        link_req;
  fct_pkg::link_t            link_rdata;
  logic                      res_valid;
  fct_pkg::res_t             res;
  logic                      res_take;

  logic                      out_valid_r, out_valid_nxt;
  fct_pkg::res_t             out_r, out_nxt;

  // sequencer: owns every read and write of both memories
  fct_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_link_index  (in_link_index),
    .in_link_is_end (in_link_is_end),
    .in_entry_index (in_entry_index),
    .used_req       (used_req),
    .used_rdata     (used_rdata),
    .link_req       (link_req),
    .link_rdata     (link_rdata),
    .res_valid      (res_valid),
    .res            (res),
    .res_take       (res_take)
  );

  // allocated marks, 32 to a row so a scan step covers a whole row
  fct_used_ram u_used_ram (
    .clk   (clk),
    .req   (used_req),
    .rdata (used_rdata)
  );

  // links: only meaningful where the mark is set, so never cleared
  fct_link_ram u_link_ram (
    .clk   (clk),
    .req   (link_req),
    .rdata (link_rdata)
  );

  // load the result register when it is empty or its word leaves this cycle
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result_index  = out_r.index;
  assign out_result_is_end = out_r.is_end;
  assign out_table_full    = out_r.full;

endmodule
